// File: sv/packet_slot_ring_fifo_macros.svh
// ----------------------------------------------------------------------------
// Packet slot ring FIFO assertion macros
// Shared helpers for the concurrent checks of the ring FIFO logic.
// ----------------------------------------------------------------------------
`ifndef PACKET_SLOT_RING_FIFO_MACROS_SVH
`define PACKET_SLOT_RING_FIFO_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSRF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PSRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/psrf_pkg.sv
// ----------------------------------------------------------------------------
// Packet slot ring FIFO package
// Status codes and the command and result records shared by the modules.
// ----------------------------------------------------------------------------
package psrf_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL_DROP = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_TOO_SMALL = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  typedef struct packed {
    logic       is_read;
    logic [7:0] data;
    logic       last;
    logic [6:0] cap;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_data;
    logic [7:0] data;
    logic       last;
    logic [6:0] length;
    logic [3:0] occ;
  } res_t;

endpackage

// File: sv/psrf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module psrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/psrf_front.sv
// ----------------------------------------------------------------------------
// Packet slot ring FIFO front end
// Accepts request items, unpacks and classifies them into commands.
// ----------------------------------------------------------------------------
module psrf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [15:0]    s_tdata,   // data_byte [7:0], reader_capacity [14:8]
  input  logic           s_tlast,
  input  logic           s_tuser,   // req_type [0]
  output logic           cmd_valid,
  output psrf_pkg::cmd_t cmd,
  input  logic           cmd_ready
);
  import psrf_pkg::*;

  logic fvalid;
  cmd_t fcmd;

  assign s_tready  = !fvalid || cmd_ready;
  assign cmd_valid = fvalid;
  assign cmd       = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (s_tready) begin
      fvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fcmd.is_read <= s_tuser;
      fcmd.data    <= s_tuser ? 8'd0 : s_tdata[7:0];
      fcmd.last    <= s_tuser ? 1'b0 : s_tlast;
      fcmd.cap     <= s_tuser ? s_tdata[14:8] : 7'd0;
    end
  end

endmodule

// File: sv/psrf_queue.sv
// ----------------------------------------------------------------------------
// Packet slot ring FIFO command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module psrf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  psrf_pkg::cmd_t in_cmd,
  output logic           in_ready,
  output logic           out_valid,
  output psrf_pkg::cmd_t out_cmd,
  input  logic           out_ready
);
  import psrf_pkg::*;

  cmd_t       ent [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_cmd   = ent[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= in_cmd;
    end
  end

endmodule

// File: sv/psrf_back.sv
// ----------------------------------------------------------------------------
// Packet slot ring FIFO back end
// Executes write and read commands against the slot ring and emits results.
// ----------------------------------------------------------------------------
`include "packet_slot_ring_fifo_macros.svh"

module psrf_back #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  psrf_pkg::cmd_t cmd,
  output logic           cmd_ready,
  output logic           res_valid,
  output psrf_pkg::res_t res,
  input  logic           res_ready
);
  import psrf_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = $clog2(SLOT_BYTES + 1);
  localparam int IW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int BD = SLOTS * (2 ** IW);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LEN    = 2'd1;
  localparam logic [1:0] S_CHK    = 2'd2;
  localparam logic [1:0] S_STREAM = 2'd3;

  logic [1:0]    state, state_next;
  logic [SW-1:0] write_slot, write_slot_next;
  logic [SW-1:0] read_slot, read_slot_next;
  logic [CW-1:0] count, count_next;
  logic [FW-1:0] fill, fill_next;
  logic          drop, drop_next;
  logic          ovf, ovf_next;
  logic [6:0]    rd_cap, rd_cap_next;
  logic [SW-1:0] rd_slot, rd_slot_next;
  logic [FW-1:0] rd_len, rd_len_next;
  logic [FW-1:0] rd_idx, rd_idx_next;
  logic [FW-1:0] out_idx, out_idx_next;
  logic          dv, dv_next;
  logic          ovalid;
  res_t          ores;

  logic          can_emit;
  logic          emit;
  res_t          res_new;
  logic [FW-1:0] fill_after;
  logic          ovf_after;
  logic          start_drop;
  logic          emit_now;
  logic          bw_en;
  logic          bren;
  logic          lw_en;
  logic [7:0]    b_rdata;
  logic [FW-1:0] l_rdata;
  logic [6:0]    len_ext;
  logic [CW+3:0] occ_ext;

  psrf_ram #(.WIDTH(8), .DEPTH(BD)) u_bytes (
    .clk   (clk),
    .we    (bw_en),
    .waddr ({write_slot, fill[IW-1:0]}),
    .wdata (cmd.data),
    .re    (bren),
    .raddr ({rd_slot, rd_idx[IW-1:0]}),
    .rdata (b_rdata)
  );

  psrf_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_lengths (
    .clk   (clk),
    .we    (lw_en),
    .waddr (write_slot),
    .wdata (fill_after),
    .re    (1'b1),
    .raddr (read_slot),
    .rdata (l_rdata)
  );

  assign can_emit  = !ovalid || res_ready;
  assign res_valid = ovalid;
  assign res       = ores;
  assign len_ext   = 7'(l_rdata);
  assign occ_ext   = (CW + 4)'(count_next);

  always_comb begin
    state_next      = state;
    write_slot_next = write_slot;
    read_slot_next  = read_slot;
    count_next      = count;
    fill_next       = fill;
    drop_next       = drop;
    ovf_next        = ovf;
    rd_cap_next     = rd_cap;
    rd_slot_next    = rd_slot;
    rd_len_next     = rd_len;
    rd_idx_next     = rd_idx;
    out_idx_next    = out_idx;
    dv_next         = dv;
    cmd_ready       = 1'b0;
    emit            = 1'b0;
    res_new         = '0;
    bw_en           = 1'b0;
    bren            = 1'b0;
    lw_en           = 1'b0;
    emit_now        = 1'b0;
    start_drop      = 1'b0;
    fill_after      = fill;
    ovf_after       = ovf;
    case (state)
      S_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_ready = 1'b1;
          if (cmd.is_read) begin
            rd_cap_next = cmd.cap;
            if (count == '0) begin
              emit           = 1'b1;
              res_new.status = ST_EMPTY;
              res_new.last   = 1'b1;
            end else begin
              state_next = S_LEN;
            end
          end else begin
            start_drop = (fill == '0) && !drop && (count == CW'(SLOTS));
            if (drop || start_drop) begin
              if (cmd.last) begin
                drop_next      = 1'b0;
                emit           = 1'b1;
                res_new.status = ST_FULL_DROP;
                res_new.last   = 1'b1;
              end else begin
                drop_next = 1'b1;
              end
            end else begin
              if (fill < FW'(SLOT_BYTES)) begin
                bw_en      = 1'b1;
                fill_after = fill + 1'b1;
              end else begin
                ovf_after = 1'b1;
              end
              if (cmd.last) begin
                lw_en           = 1'b1;
                write_slot_next = (write_slot == SW'(SLOTS - 1)) ? '0 : write_slot + 1'b1;
                count_next      = count + 1'b1;
                fill_next       = '0;
                ovf_next        = 1'b0;
                emit            = 1'b1;
                res_new.status  = ovf_after ? ST_TRUNC : ST_OK;
                res_new.last    = 1'b1;
                res_new.length  = 7'(fill_after);
              end else begin
                fill_next = fill_after;
                ovf_next  = ovf_after;
              end
            end
          end
        end
      end
      S_LEN: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (len_ext > rd_cap) begin
          if (can_emit) begin
            emit           = 1'b1;
            res_new.status = ST_TOO_SMALL;
            res_new.last   = 1'b1;
            res_new.length = len_ext;
            state_next     = S_IDLE;
          end
        end else begin
          read_slot_next = (read_slot == SW'(SLOTS - 1)) ? '0 : read_slot + 1'b1;
          count_next     = count - 1'b1;
          rd_slot_next   = read_slot;
          rd_len_next    = l_rdata;
          rd_idx_next    = '0;
          out_idx_next   = '0;
          dv_next        = 1'b0;
          state_next     = S_STREAM;
        end
      end
      S_STREAM: begin
        emit_now = dv && can_emit;
        bren     = (rd_idx < rd_len) && (!dv || emit_now);
        if (bren) begin
          rd_idx_next = rd_idx + 1'b1;
          dv_next     = 1'b1;
        end else if (emit_now) begin
          dv_next = 1'b0;
        end
        if (emit_now) begin
          emit            = 1'b1;
          res_new.status  = ST_OK;
          res_new.is_data = 1'b1;
          res_new.data    = b_rdata;
          res_new.last    = (out_idx == rd_len - 1'b1);
          res_new.length  = 7'(rd_len);
          out_idx_next    = out_idx + 1'b1;
          if (out_idx == rd_len - 1'b1) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res_new.occ = occ_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      read_slot  <= '0;
      count      <= '0;
      fill       <= '0;
      drop       <= 1'b0;
      ovf        <= 1'b0;
      dv         <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      state      <= state_next;
      write_slot <= write_slot_next;
      read_slot  <= read_slot_next;
      count      <= count_next;
      fill       <= fill_next;
      drop       <= drop_next;
      ovf        <= ovf_next;
      dv         <= dv_next;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (res_ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_cap  <= rd_cap_next;
    rd_slot <= rd_slot_next;
    rd_len  <= rd_len_next;
    rd_idx  <= rd_idx_next;
    out_idx <= out_idx_next;
    if (emit) begin
      ores <= res_new;
    end
  end

  `PSRF_ASSERT(a_count_range, 1'b1, count <= CW'(SLOTS), "Packet count exceeds ring size.")
  `PSRF_ASSERT(a_drop_clean, drop, (fill == '0) && !ovf, "Dropped packet holds fill state.")
  `PSRF_ASSERT_NEXT(a_read_frees, (state == S_CHK) && (state_next == S_STREAM), count != CW'(SLOTS), "Read did not free a slot.")
  `PSRF_ASSERT(a_stream_index, (state == S_STREAM) && dv, out_idx < rd_len, "Stream index ran past the packet length.")

endmodule

// File: sv/packet_slot_ring_fifo.sv
// ----------------------------------------------------------------------------
// Packet slot ring FIFO
// Ring of fixed-size packet slots with byte-wise writes and packet reads.
// ----------------------------------------------------------------------------
// An accepted item passes the front register and the command queue before the
// back end registers any result of it in the result register. The back end takes
// write items back to back, so packet bytes stream in at one per cycle; the
// back end holds any item while its result register is full and not being
// drained. A read passes state S_LEN for the stored length and S_CHK for its
// check against the capacity, then fetches its first byte, and then delivers
// one byte per cycle through the registered read port of the byte memory while
// the result register drains. The back end works on one item at a time, and the
// next item can start the cycle after a read's last result is registered.
module packet_slot_ring_fifo #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte [7:0], reader_capacity [14:8]
  input  logic        s_tlast,   // last_byte
  input  logic        s_tuser,   // req_type [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte [7:0], packet_length [14:8], occupancy [18:15]
  output logic        m_tlast,   // out_last
  output logic [3:0]  m_tuser    // status [2:0], is_data [3]
);
  import psrf_pkg::*;

  logic f_valid;
  cmd_t f_cmd;
  logic f_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_ready;
  res_t res;

  psrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  psrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_cmd    (f_cmd),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  psrf_back #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  assign m_tdata = {5'd0, res.occ, res.length, res.data};
  assign m_tlast = res.last;
  assign m_tuser = {res.is_data, res.status};

endmodule
